FILE: design/edh_pkg.sv
`default_nettype none
package edh_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 11;
    localparam int OCNT_W     = 20;
    localparam int TOT_W      = 22;
    localparam int FIFO_DEPTH = 4;
    localparam int CFG_IDX_W  = 3;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL   = 3'd4;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [PIX_W-1:0] RST_WEAK   = 8'd25;
    localparam logic [PIX_W-1:0] RST_STRONG = 8'd255;
    localparam logic [PIX_W-1:0] RST_ZERO   = 8'd0;

    localparam logic [ROW_W-1:0] ROW_SAT = '1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_row_pair;

    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] pixel;
    } t_out_item;

    // zero counts as one, large values saturate to the cap
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > cap) begin
            res = cap;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/edge_hysteresis_3x3_top.sv
`default_nettype none
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+----------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: pixel_in, tuser: req_type
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: pixel_out, tlast: frame_end
// cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one request per clock while s_axis_tready is high; a result leaves after the request
// that completes its 3x3 window (one line plus one pixel behind the input)
// the two row stores share one pair-wide memory, read at accept and written back in the next
// cycle with forwarding of the last write; a four-entry output queue absorbs stalls
// reset clears counters and the window, the row memory is not cleared
// a configuration write holds both request ports while the output
// row and column are re-derived by a 20-step divider
module edge_hysteresis_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [edh_pkg::PIX_W-1:0]         s_axis_tdata,   // [7:0] pixel_in
    input  wire logic                              s_axis_tuser,   // [0] req_type
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [edh_pkg::PIX_W-1:0]              m_axis_tdata,   // [7:0] pixel_out
    output logic                                   m_axis_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [edh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [edh_pkg::DIM_W-1:0]         i_cfg_data
);
    import edh_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W   = (COL_W + 1 > DIM_W + 1) ? COL_W + 1 : DIM_W + 1;
    localparam int W_CAP_I = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int H_CAP_I = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
    localparam logic [DIM_W-1:0] W_CAP = DIM_W'(W_CAP_I);
    localparam logic [DIM_W-1:0] H_CAP = DIM_W'(H_CAP_I);
    localparam int TOTAL_RST = ((640 > W_CAP_I) ? W_CAP_I : 640) *
                               ((480 > H_CAP_I) ? H_CAP_I : 480);
    localparam int FCNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV} t_state;

    // configuration
    logic [DIM_W-1:0]   r_cfg_w;
    logic [DIM_W-1:0]   r_cfg_h;
    logic [PIX_W-1:0]   r_weak;
    logic [PIX_W-1:0]   r_strong;
    logic [PIX_W-1:0]   r_zero;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic               cfg_fire;

    t_state             r_state;
    logic [TOT_W-1:0]   r_total;

    // input and output position counters
    logic [COL_W-1:0]   r_in_col,  n_in_col;
    logic [ROW_W-1:0]   r_in_row,  n_in_row;
    logic [OCNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic [OCNT_W-1:0]  r_orow,    n_orow;
    logic [DIM_W-1:0]   r_ocol,    n_ocol;

    // accept stage
    logic               in_fire;
    logic               is_flush;
    logic               skip;
    logic               take;
    logic [PIX_W-1:0]   pix_eff;
    logic [CMP_W-1:0]   col_ext;
    logic [CMP_W-1:0]   w_ext;
    logic [CMP_W-1:0]   col_inc;
    logic               emit;
    logic [OCNT_W-1:0]  ocnt_inc;
    logic               frame_end;
    logic [DIM_W:0]     ocol_ext;
    logic [DIM_W:0]     ocol_inc;
    logic [DIM_W:0]     w12;
    logic [OCNT_W:0]    orow_ext;
    logic [OCNT_W:0]    h21;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [8:0]         nb_ok;

    // writeback stage
    logic               r_s1_valid;
    logic [COL_W-1:0]   r_s1_col;
    logic [PIX_W-1:0]   r_s1_pix;
    logic               r_s1_emit;
    logic               r_s1_fe;
    logic [8:0]         r_s1_nb;
    logic               r_fwd_valid;
    logic [COL_W-1:0]   r_fwd_col;
    t_row_pair          r_fwd_data;
    t_row_pair          rd_data;
    t_row_pair          pair;
    t_row_pair          wr_data;
    logic [PIX_W-1:0]   r_win [9];
    logic [PIX_W-1:0]   win_nx [9];
    logic               found;
    logic [PIX_W-1:0]   result;
    logic               push;
    t_out_item          push_item;
    t_out_item          head_item;
    logic [FCNT_W-1:0]  fifo_count;
    logic [FCNT_W-1:0]  pending;

    logic               div_done;
    logic [OCNT_W-1:0]  div_quo;
    logic [DIM_W-1:0]   div_rem;

    assign w        = clamp_dim(r_cfg_w, W_CAP);
    assign h        = clamp_dim(r_cfg_h, H_CAP);
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    assign o_cfg_ready   = r_state == ST_IDLE;
    assign pending       = fifo_count + FCNT_W'(r_s1_valid && r_s1_emit);
    assign s_axis_tready = (r_state == ST_IDLE) && (pending < FCNT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= RST_WIDTH;
            r_cfg_h  <= RST_HEIGHT;
            r_weak   <= RST_WEAK;
            r_strong <= RST_STRONG;
            r_zero   <= RST_ZERO;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_data;
                CFG_WEAK_LEVEL:   r_weak   <= i_cfg_data[PIX_W-1:0];
                CFG_STRONG_LEVEL: r_strong <= i_cfg_data[PIX_W-1:0];
                CFG_ZERO_LEVEL:   r_zero   <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // after a write the output row and column follow the new width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= TOT_W'(TOTAL_RST);
        end else begin
            unique case (r_state)
                ST_IDLE:  if (cfg_fire) r_state <= ST_START;
                ST_START: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        r_total <= TOT_W'(w) * TOT_W'(h);
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    edh_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == ST_START),
        .i_dividend  (r_out_cnt),
        .i_divisor   (w),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        in_fire  = s_axis_tvalid && s_axis_tready;
        is_flush = s_axis_tuser == REQ_FLUSH;
        skip     = is_flush && (r_in_row == '0) && (r_in_col == '0);
        take     = in_fire && !skip;
        pix_eff  = (is_flush || (r_in_row >= h)) ? '0 : s_axis_tdata;

        col_ext = CMP_W'(r_in_col);
        w_ext   = CMP_W'(w);
        col_inc = col_ext + CMP_W'(1);
        emit    = (r_in_row >= ROW_W'(2))
               || ((r_in_row == ROW_W'(1)) && (r_in_col != '0))
               || ((r_in_row == '0) && (col_ext >= w_ext + CMP_W'(1)));

        ocnt_inc  = r_out_cnt + 1'b1;
        frame_end = (TOT_W'(ocnt_inc) >= r_total) || (ocnt_inc == '0);

        // neighbor positions that lie inside the image
        ocol_ext  = {1'b0, r_ocol};
        ocol_inc  = ocol_ext + 1'b1;
        w12       = {1'b0, w};
        orow_ext  = {1'b0, r_orow};
        h21       = (OCNT_W + 1)'(h);
        row_ok[0] = (r_orow != '0) && ((orow_ext - 1'b1) < h21);
        row_ok[1] = orow_ext < h21;
        row_ok[2] = (orow_ext + 1'b1) < h21;
        col_ok[0] = (r_ocol != '0) && ((ocol_ext - 1'b1) < w12);
        col_ok[1] = ocol_ext < w12;
        col_ok[2] = ocol_inc < w12;
        for (int k = 0; k < 9; k++) begin
            nb_ok[k] = (k != 4) && row_ok[k / 3] && col_ok[k % 3];
        end

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_cnt = r_out_cnt;
        n_orow    = r_orow;
        n_ocol    = r_ocol;
        if (take) begin
            if (col_inc >= w_ext) begin
                n_in_col = '0;
                if (r_in_row != ROW_SAT) begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = COL_W'(col_inc);
            end
            if (emit) begin
                if (frame_end) begin
                    n_out_cnt = '0;
                    n_orow    = '0;
                    n_ocol    = '0;
                    n_in_col  = '0;
                    n_in_row  = '0;
                end else begin
                    n_out_cnt = ocnt_inc;
                    if (ocol_inc >= w12) begin
                        n_ocol = '0;
                        n_orow = r_orow + 1'b1;
                    end else begin
                        n_ocol = ocol_inc[DIM_W-1:0];
                    end
                end
            end
        end else if (div_done) begin
            n_orow = div_quo;
            n_ocol = div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_cnt  <= '0;
            r_orow     <= '0;
            r_ocol     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_cnt  <= n_out_cnt;
            r_orow     <= n_orow;
            r_ocol     <= n_ocol;
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_col  <= r_in_col;
            r_s1_pix  <= pix_eff;
            r_s1_emit <= emit;
            r_s1_fe   <= emit && frame_end;
            r_s1_nb   <= nb_ok;
        end
    end

    edh_row_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data)
    );

    // the last written pair is always the newest value of its column
    always_comb begin
        pair = (r_fwd_valid && (r_fwd_col == r_s1_col)) ? r_fwd_data : rd_data;
        wr_data.upper  = pair.middle;
        wr_data.middle = r_s1_pix;

        win_nx[0] = r_win[1];
        win_nx[1] = r_win[2];
        win_nx[2] = pair.upper;
        win_nx[3] = r_win[4];
        win_nx[4] = r_win[5];
        win_nx[5] = pair.middle;
        win_nx[6] = r_win[7];
        win_nx[7] = r_win[8];
        win_nx[8] = r_s1_pix;

        found = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (r_s1_nb[k] && (win_nx[k] == r_strong)) begin
                found = 1'b1;
            end
        end
        // weak test first, even when weak equals strong
        if (win_nx[4] == r_weak) begin
            result = found ? r_strong : r_zero;
        end else begin
            result = win_nx[4];
        end

        push                = r_s1_valid && r_s1_emit;
        push_item.pixel     = result;
        push_item.frame_end = r_s1_fe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            r_fwd_valid <= 1'b1;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= win_nx[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fwd_col  <= r_s1_col;
            r_fwd_data <= wr_data;
        end
    end

    edh_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_valid (m_axis_tvalid),
        .o_item  (head_item),
        .i_ready (m_axis_tready),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = head_item.pixel;
    assign m_axis_tlast = head_item.frame_end;

endmodule
`default_nettype wire

FILE: design/edh_row_mem.sv
`default_nettype none
module edh_row_mem #(
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output edh_pkg::t_row_pair      o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  edh_pkg::t_row_pair      i_wr_data
);
    import edh_pkg::*;

    t_row_pair r_mem [DEPTH];
    t_row_pair r_rd_data;

    // read returns the old entry when the same address is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: design/edh_div.sv
`default_nettype none
module edh_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [edh_pkg::OCNT_W-1:0]  i_dividend,
    input  wire logic [edh_pkg::DIM_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [edh_pkg::OCNT_W-1:0]       o_quotient,
    output logic [edh_pkg::DIM_W-1:0]        o_remainder
);
    import edh_pkg::*;

    localparam int CNT_W = $clog2(OCNT_W);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [OCNT_W-1:0]   r_quo;
    logic [DIM_W-1:0]    r_rem;
    logic                r_done;
    logic [DIM_W:0]      shifted;
    logic                fits;
    logic [DIM_W:0]      diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted = {r_rem, r_quo[OCNT_W-1]};
        fits    = shifted >= {1'b0, i_divisor};
        diff    = shifted - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quo   <= i_dividend;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
                    r_quo <= {r_quo[OCNT_W-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(OCNT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

FILE: design/edh_out_fifo.sv
`default_nettype none
module edh_out_fifo (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_push,
    input  edh_pkg::t_out_item                           i_item,
    output logic                                         o_valid,
    output edh_pkg::t_out_item                           o_item,
    input  wire logic                                    i_ready,
    output logic [$clog2(edh_pkg::FIFO_DEPTH+1)-1:0]     o_count
);
    import edh_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_out_item          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: test/edge_hysteresis_3x3_top_tb.sv
`timescale 1ns / 100ps

module edge_hysteresis_3x3_top_tb;
    import edh_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;
    localparam int RAND_TARGET = 900;
    localparam int CALM_FROM = 760;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT = 1000000;

    // expected filtered pixels, worked out from the accepted pixel requests
    class hysteresis_scoreboard;
        logic [DIM_W-1:0] img_w, img_h;
        logic [PIX_W-1:0] weak_lvl, strong_lvl, zero_lvl;
        logic [PIX_W-1:0] upper_row [MAX_W];
        logic [PIX_W-1:0] middle_row [MAX_W];
        logic [PIX_W-1:0] win [9];
        int unsigned col_n, row_n;
        logic [OCNT_W-1:0] out_cnt;
        t_out_item filtered_due [$];
        int mismatches, results, frames;

        function new();
            img_w = RST_WIDTH;
            img_h = RST_HEIGHT;
            weak_lvl = RST_WEAK;
            strong_lvl = RST_STRONG;
            zero_lvl = RST_ZERO;
            foreach (upper_row[i]) begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col_n = 0;
            row_n = 0;
            out_cnt = '0;
            mismatches = 0;
            results = 0;
            frames = 0;
        endfunction

        function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned cap);
            if (v == 0) return 1;
            return (v > cap) ? cap : v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  img_w = val;
                CFG_IMAGE_HEIGHT: img_h = val;
                CFG_WEAK_LEVEL:   weak_lvl = val[PIX_W-1:0];
                CFG_STRONG_LEVEL: strong_lvl = val[PIX_W-1:0];
                CFG_ZERO_LEVEL:   zero_lvl = val[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_frame();
            return col_n != 0 || row_n != 0;
        endfunction

        function bit taking_pixels();
            return row_n < eff_dim(img_h, MAX_H);
        endfunction

        function int pending();
            return filtered_due.size();
        endfunction

        function void accept_pixel_req(logic kind, logic [PIX_W-1:0] pix);
            int unsigned w, h, pos, tot, crow, ccol;
            int r, dr, dc, nr, nc;
            logic [PIX_W-1:0] v, up, mid, res;
            bit hit;
            t_out_item item;
            w = eff_dim(img_w, MAX_W);
            h = eff_dim(img_h, MAX_H);
            // a flush before the first pixel of a frame does nothing
            if (kind == REQ_FLUSH && row_n == 0 && col_n == 0) return;
            v = (kind == REQ_FLUSH || row_n >= h) ? '0 : pix;
            up = upper_row[col_n];
            mid = middle_row[col_n];
            upper_row[col_n] = mid;
            middle_row[col_n] = v;
            for (r = 0; r < 3; r++) begin
                win[r*3] = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = v;
            pos = row_n * w + col_n;
            col_n++;
            if (col_n >= w) begin
                col_n = 0;
                if (row_n < 2047) row_n++;
            end
            if (pos < w + 1) return;

            crow = out_cnt / w;
            ccol = out_cnt % w;
            tot = w * h;
            res = win[4];
            // weak test wins even when weak and strong levels are equal
            if (win[4] == weak_lvl) begin
                hit = 0;
                for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                        nr = int'(crow) + dr;
                        nc = int'(ccol) + dc;
                        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 &&
                            nr < int'(h) && nc < int'(w) &&
                            win[(dr+1)*3 + dc + 1] == strong_lvl)
                            hit = 1;
                    end
                end
                res = hit ? strong_lvl : zero_lvl;
            end
            out_cnt = out_cnt + 1'b1;
            item.pixel = res;
            item.frame_end = 1'b0;
            if (out_cnt >= tot || out_cnt == 0) begin
                item.frame_end = 1'b1;
                out_cnt = '0;
                col_n = 0;
                row_n = 0;
            end
            filtered_due.push_back(item);
        endfunction

        function void check_pixel_out(logic [PIX_W-1:0] pix, logic last);
            t_out_item want;
            if (filtered_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel %0d last %b", $realtime, pix, last);
                return;
            end
            want = filtered_due.pop_front();
            results++;
            if (want.frame_end) frames++;
            if (pix !== want.pixel || last !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel %0d last %b, expected pixel %0d last %b",
                             $realtime, pix, last, want.pixel, want.frame_end);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [PIX_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0] i_cfg_data;

    hysteresis_scoreboard board = new();
    bit idle_on = 1'b1;
    bit calm = 1'b0;
    int stall_left = 0;
    int cycle_cnt = 0;
    int rand_items = 0;
    int reqs = 0;
    int cfg_writes = 0;

    edge_hysteresis_3x3_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check, then decide on a stall burst for the next cycle
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                board.check_pixel_out(m_axis_tdata, m_axis_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2: return board.weak_lvl;
            3, 4:    return board.strong_lvl;
            5:       return board.zero_lvl;
            6:       return 8'hFF;
            7:       return 8'h00;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.accept_pixel_req(kind, pix);
        reqs++;
    endtask

    // valid stays up between back-to-back writes, dropped after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val,
                             input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.set_reg(idx, val);
        cfg_writes++;
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic retune(input logic [DIM_W-1:0] h);
        logic [PIX_W-1:0] weak_val;
        weak_val = pick_level();
        write_reg(CFG_IMAGE_HEIGHT, h, 1'b1);
        write_reg(CFG_WEAK_LEVEL, DIM_W'(weak_val), 1'b1);
        write_reg(CFG_STRONG_LEVEL,
                  DIM_W'(($urandom_range(0, 7) == 0) ? weak_val : pick_level()), 1'b1);
        write_reg(CFG_ZERO_LEVEL, DIM_W'(pick_level()), 1'b0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        // let requests that produce nothing leave the pipeline
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frame(input bit counted, input bit mid_retune);
        int n, cut;
        logic kind;
        n = 0;
        cut = mid_retune ? $urandom_range(1, 60) : 0;
        send_item(REQ_PIXEL, pick_pixel());
        n++;
        while (board.in_frame()) begin
            if (n == cut) begin
                // width stays, so no unwritten row entry reaches a result
                wait_drained();
                retune(DIM_W'($urandom_range(0, 8)));
            end
            if (board.taking_pixels())
                kind = ($urandom_range(0, 29) == 0) ? REQ_FLUSH : REQ_PIXEL;
            else
                kind = ($urandom_range(0, 1) == 0) ? REQ_PIXEL : REQ_FLUSH;
            send_item(kind, pick_pixel());
            n++;
        end
        if (counted) rand_items += n;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_PIXEL;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small frames with the reset levels
        write_reg(CFG_IMAGE_WIDTH, 11'd3, 1'b1);
        write_reg(CFG_IMAGE_HEIGHT, 11'd2, 1'b0);
        send_item(REQ_FLUSH, 8'hA5);
        send_item(REQ_PIXEL, 8'd255); send_item(REQ_PIXEL, 8'd25); send_item(REQ_PIXEL, 8'd7);
        send_item(REQ_PIXEL, 8'd25); send_item(REQ_PIXEL, 8'd0); send_item(REQ_PIXEL, 8'd25);
        send_item(REQ_FLUSH, 8'h5A); send_item(REQ_PIXEL, 8'd200);
        send_item(REQ_FLUSH, 8'hFF); send_item(REQ_PIXEL, 8'd99);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_PIXEL, 8'd25); send_item(REQ_FLUSH, 8'd255); send_item(REQ_PIXEL, 8'd255);
        send_item(REQ_PIXEL, 8'd25); send_item(REQ_PIXEL, 8'd25); send_item(REQ_PIXEL, 8'd25);
        send_item(REQ_PIXEL, 8'd0); send_item(REQ_PIXEL, 8'd255);
        send_item(REQ_FLUSH, 8'd1); send_item(REQ_FLUSH, 8'd128);

        // tallest image, with out-of-range register values
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 11'd0, 1'b1);
        retune(11'd2047);
        run_frame(1'b0, 1'b0);

        while (rand_items < RAND_TARGET) begin
            wait_drained();
            calm = rand_items >= CALM_FROM;
            idle_on = !calm && $urandom_range(0, 3) != 0;
            write_reg(CFG_IMAGE_WIDTH,
                      DIM_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12)), 1'b1);
            retune(DIM_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8)));
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(REQ_FLUSH, pick_pixel());
                run_frame(1'b1, $urandom_range(0, 5) == 0);
            end
        end

        wait_drained();
        $display("sent %0d pixel/flush requests with %0d register writes, images 1x1 up to 1024",
                 reqs, cfg_writes);
        $display("checked %0d filtered pixels over %0d frames", board.results, board.frames);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
